// ----- rtl/vhtci_pkg.sv -----
// Shared types and constants for the VHT capability intersection block.
package vhtci_pkg;

  // Number of 2-bit MCS lanes that take part in the TX map intersection.
  localparam int unsigned STREAM_LANES = 8;
  localparam int unsigned MCS_LANES_TOTAL = 8;

  localparam logic [1:0] MCS_UNSUPPORTED = 2'h3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_CAPS       = 3'd0,
    REG_LOCAL_RX_MCS_MAP = 3'd1,
    REG_LOCAL_TX_MCS_MAP = 3'd2,
    REG_ALLOW_80P80      = 3'd3,
    REG_ALLOW_160        = 3'd4,
    REG_STBC_TX_ON       = 3'd5,
    REG_STBC_RX_ON       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] peer_caps;
    logic [15:0] peer_tx_mcs_map;
    logic        station_mode;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] cap_word;
    logic [15:0] rx_mcs_out;
    logic [15:0] tx_mcs_out;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] local_caps;
    logic [15:0] local_rx_mcs_map;
    logic [15:0] local_tx_mcs_map;
    logic        allow_80p80;
    logic        allow_160;
    logic        stbc_tx_on;
    logic        stbc_rx_on;
  } cfg_t;

endpackage

// ----- rtl/vhtci_merge.sv -----
// Combinational capability and MCS map intersection for one beat.
module vhtci_merge (
  input  vhtci_pkg::cfg_t      cfg,
  input  vhtci_pkg::in_beat_t  beat_in,
  output vhtci_pkg::out_beat_t beat_out
);

  logic [31:0] lc;
  logic [31:0] pc;
  logic        sta;
  logic [1:0]  width_op;
  logic [1:0]  width_res;
  logic        tx_stbc_op;
  logic        tx_stbc;
  logic [2:0]  rx_stbc_op;
  logic [2:0]  rx_stbc;
  logic        su_bfr;
  logic        su_bfe;
  logic        htc;
  logic [31:0] cap;
  logic [15:0] txmap;
  logic [1:0]  lane_a;
  logic [1:0]  lane_b;

  always_comb begin
    sta = beat_in.station_mode;
    lc  = cfg.local_caps;
    pc  = sta ? beat_in.peer_caps : cfg.local_caps;
    cap = '0;

    cap[1:0] = (lc[1:0] < pc[1:0]) ? lc[1:0] : pc[1:0];

    // Width is stepped down one level at a time; the reserved code passes.
    width_op = pc[3:2];
    if (width_op == 2'd2 && !cfg.allow_80p80) begin
      width_op = 2'd1;
    end
    if (width_op == 2'd1 && !cfg.allow_160) begin
      width_op = 2'd0;
    end
    width_res = (lc[3:2] < width_op) ? lc[3:2] : width_op;
    cap[3:2]  = width_res;

    cap[4] = lc[4] & pc[4];
    cap[5] = lc[5] & pc[5];
    cap[6] = lc[6] & pc[6];

    // STBC crosses over in station mode: our TX pairs with the peer's RX.
    tx_stbc_op = sta ? (|beat_in.peer_caps[10:8]) : lc[7];
    tx_stbc    = lc[7] & tx_stbc_op & cfg.stbc_tx_on;
    rx_stbc_op = sta ? {2'b00, beat_in.peer_caps[7]} : lc[10:8];
    rx_stbc    = (lc[10:8] < rx_stbc_op) ? lc[10:8] : rx_stbc_op;
    if (!cfg.stbc_rx_on) begin
      rx_stbc = 3'd0;
    end
    if (rx_stbc == 3'd0) begin
      tx_stbc = 1'b0;
    end
    cap[7]    = tx_stbc;
    cap[10:8] = rx_stbc;

    su_bfr  = lc[11] & pc[11];
    su_bfe  = lc[12] & pc[12];
    cap[11] = su_bfr;
    cap[12] = su_bfe;
    cap[15:13] = su_bfe ? ((lc[15:13] < pc[15:13]) ? lc[15:13] : pc[15:13]) : 3'd0;
    cap[18:16] = su_bfr ? ((lc[18:16] < pc[18:16]) ? lc[18:16] : pc[18:16]) : 3'd0;
    cap[19] = su_bfr & sta & lc[19] & pc[19];
    cap[20] = su_bfe & !sta & lc[20] & pc[20];

    cap[21] = lc[21] & pc[21];
    htc     = lc[22] & pc[22];
    cap[22] = htc;
    cap[25:23] = (lc[25:23] < pc[25:23]) ? lc[25:23] : pc[25:23];
    cap[27:26] = htc ? ((lc[27:26] < pc[27:26]) ? lc[27:26] : pc[27:26]) : 2'd0;

    // Antenna pattern consistency takes the larger value.
    cap[28] = lc[28] | pc[28];
    cap[29] = lc[29] | pc[29];

    txmap = cfg.local_tx_mcs_map;
    for (int i = 0; i < vhtci_pkg::MCS_LANES_TOTAL; i++) begin
      lane_a = cfg.local_tx_mcs_map[2*i +: 2];
      lane_b = beat_in.peer_tx_mcs_map[2*i +: 2];
      if (sta && i < vhtci_pkg::STREAM_LANES) begin
        if (lane_a == vhtci_pkg::MCS_UNSUPPORTED || lane_b == vhtci_pkg::MCS_UNSUPPORTED) begin
          txmap[2*i +: 2] = vhtci_pkg::MCS_UNSUPPORTED;
        end else begin
          txmap[2*i +: 2] = (lane_a < lane_b) ? lane_a : lane_b;
        end
      end
    end

    beat_out.cap_word   = cap;
    beat_out.rx_mcs_out = cfg.local_rx_mcs_map;
    beat_out.tx_mcs_out = txmap;
  end

endmodule

// ----- rtl/vht_capability_intersect.sv -----
// Top level of the VHT capability intersection block.
//
//   Channel  Ports                             Direction  Payload
//   in       in_valid, in_stall, in_data       inbound    peer caps, peer TX map, mode
//   out      out_valid, out_stall, out_data    outbound   cap word, RX map, TX map
//   cfg      cfg_we, cfg_idx, cfg_wdata        inbound    local caps, maps, permits
//
// A beat is captured in the input register, the capability merge runs in the
// following cycle, and the result is held in the output register. One beat is
// accepted per cycle as long as the output is taken.
// rst_n is synchronous and active low; it empties both registers and loads the
// configuration reset values. A stall on the output backs up into in_stall only
// when both registers hold beats.
module vht_capability_intersect (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  vhtci_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output vhtci_pkg::out_beat_t                out_data,
  input  logic                                cfg_we,
  input  logic [vhtci_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [vhtci_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  vhtci_pkg::cfg_t      cfg_r;
  vhtci_pkg::in_beat_t  in_beat_r;
  logic                 in_vld_r;
  vhtci_pkg::out_beat_t out_beat_r;
  logic                 out_vld_r;
  vhtci_pkg::out_beat_t merged;
  logic                 out_load;
  logic                 in_load;

  // Configuration registers. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_caps       <= 32'h0;
      cfg_r.local_rx_mcs_map <= 16'hFFFF;
      cfg_r.local_tx_mcs_map <= 16'hFFFF;
      cfg_r.allow_80p80      <= 1'b0;
      cfg_r.allow_160        <= 1'b0;
      cfg_r.stbc_tx_on       <= 1'b0;
      cfg_r.stbc_rx_on       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vhtci_pkg::REG_LOCAL_CAPS:       cfg_r.local_caps       <= cfg_wdata;
        vhtci_pkg::REG_LOCAL_RX_MCS_MAP: cfg_r.local_rx_mcs_map <= cfg_wdata[15:0];
        vhtci_pkg::REG_LOCAL_TX_MCS_MAP: cfg_r.local_tx_mcs_map <= cfg_wdata[15:0];
        vhtci_pkg::REG_ALLOW_80P80:      cfg_r.allow_80p80      <= cfg_wdata[0];
        vhtci_pkg::REG_ALLOW_160:        cfg_r.allow_160        <= cfg_wdata[0];
        vhtci_pkg::REG_STBC_TX_ON:       cfg_r.stbc_tx_on       <= cfg_wdata[0];
        vhtci_pkg::REG_STBC_RX_ON:       cfg_r.stbc_rx_on       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // The output register can load when it is empty or its beat leaves now.
  assign out_load = !out_vld_r || !out_stall;
  // The input register can load when it is empty or its beat moves on.
  assign in_stall = in_vld_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_beat_r <= in_data;
    end
  end

  vhtci_merge u_merge (
    .cfg      (cfg_r),
    .beat_in  (in_beat_r),
    .beat_out (merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_vld_r) begin
      out_beat_r <= merged;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

endmodule

// ----- dv/vhtci_tb_pkg.sv -----
// Scoreboard with a capability-negotiation predictor for the VHT capability intersection bench.
package vhtci_tb_pkg;
  import vhtci_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  class capability_scoreboard;
    cfg_t        regs;
    out_beat_t   owed_q[$];
    int unsigned mismatches;

    function new();
      regs = '0;
      regs.local_rx_mcs_map = 16'hFFFF;
      regs.local_tx_mcs_map = 16'hFFFF;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOCAL_CAPS:       regs.local_caps = data;
        REG_LOCAL_RX_MCS_MAP: regs.local_rx_mcs_map = data[15:0];
        REG_LOCAL_TX_MCS_MAP: regs.local_tx_mcs_map = data[15:0];
        REG_ALLOW_80P80:      regs.allow_80p80 = data[0];
        REG_ALLOW_160:        regs.allow_160 = data[0];
        REG_STBC_TX_ON:       regs.stbc_tx_on = data[0];
        REG_STBC_RX_ON:       regs.stbc_rx_on = data[0];
        default: ;
      endcase
    endfunction

    static function logic [2:0] lesser(logic [2:0] a, logic [2:0] b);
      return (a < b) ? a : b;
    endfunction

    static function logic [1:0] lesser2(logic [1:0] a, logic [1:0] b);
      return (a < b) ? a : b;
    endfunction

    // Works out the announced capability word and MCS maps for one peer beat.
    function out_beat_t negotiate(in_beat_t b);
      logic [31:0] lc;
      logic [31:0] pc;
      logic [31:0] cap;
      logic [1:0]  w;
      logic [1:0]  la;
      logic [1:0]  lb;
      logic [2:0]  rx_peer;
      logic [2:0]  rx_stbc;
      logic        sta;
      logic        tx_stbc;
      logic        su_bfr;
      logic        su_bfe;
      logic        htc;
      out_beat_t   r;
      int          i;
      lc = regs.local_caps;
      sta = b.station_mode;
      pc = sta ? b.peer_caps : lc;
      cap = '0;
      cap[1:0] = lesser2(lc[1:0], pc[1:0]);
      // Width is stepped down past disallowed modes before taking the minimum.
      w = pc[3:2];
      if (w == 2'd2 && !regs.allow_80p80) w = 2'd1;
      if (w == 2'd1 && !regs.allow_160) w = 2'd0;
      cap[3:2] = lesser2(lc[3:2], w);
      cap[6:4] = lc[6:4] & pc[6:4];
      // The peer's RX STBC pairs with our TX STBC and the other way round.
      tx_stbc = lc[7] & (sta ? |b.peer_caps[10:8] : lc[7]);
      rx_peer = sta ? {2'b00, b.peer_caps[7]} : lc[10:8];
      rx_stbc = regs.stbc_rx_on ? lesser(lc[10:8], rx_peer) : 3'd0;
      if (!regs.stbc_tx_on || rx_stbc == 3'd0) tx_stbc = 1'b0;
      cap[7] = tx_stbc;
      cap[10:8] = rx_stbc;
      su_bfr = lc[11] & pc[11];
      su_bfe = lc[12] & pc[12];
      cap[11] = su_bfr;
      cap[12] = su_bfe;
      cap[15:13] = su_bfe ? lesser(lc[15:13], pc[15:13]) : 3'd0;
      cap[18:16] = su_bfr ? lesser(lc[18:16], pc[18:16]) : 3'd0;
      cap[19] = su_bfr & sta & lc[19] & pc[19];
      cap[20] = su_bfe & ~sta & lc[20] & pc[20];
      cap[21] = lc[21] & pc[21];
      htc = lc[22] & pc[22];
      cap[22] = htc;
      cap[25:23] = lesser(lc[25:23], pc[25:23]);
      cap[27:26] = htc ? lesser2(lc[27:26], pc[27:26]) : 2'd0;
      cap[29:28] = lc[29:28] | pc[29:28];
      r.cap_word = cap;
      r.rx_mcs_out = regs.local_rx_mcs_map;
      r.tx_mcs_out = regs.local_tx_mcs_map;
      if (sta) begin
        for (i = 0; i < STREAM_LANES && i < MCS_LANES_TOTAL; i++) begin
          la = regs.local_tx_mcs_map[2*i +: 2];
          lb = b.peer_tx_mcs_map[2*i +: 2];
          r.tx_mcs_out[2*i +: 2] = (la == MCS_UNSUPPORTED || lb == MCS_UNSUPPORTED) ?
                                   MCS_UNSUPPORTED : lesser2(la, lb);
        end
      end
      return r;
    endfunction

    function void note_input(in_beat_t b);
      owed_q.push_back(negotiate(b));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (owed_q.size() == 0) begin
        flag($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = owed_q.pop_front();
      if (got.cap_word !== want.cap_word)
        flag($sformatf("cap_word mismatch: expected %08h, got %08h",
                       want.cap_word, got.cap_word));
      if (got.rx_mcs_out !== want.rx_mcs_out)
        flag($sformatf("rx_mcs_out mismatch: expected %04h, got %04h",
                       want.rx_mcs_out, got.rx_mcs_out));
      if (got.tx_mcs_out !== want.tx_mcs_out)
        flag($sformatf("tx_mcs_out mismatch: expected %04h, got %04h",
                       want.tx_mcs_out, got.tx_mcs_out));
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function bit failed();
      return mismatches != 0 || owed_q.size() != 0;
    endfunction
  endclass

endpackage

// ----- dv/vht_capability_intersect_tb.sv -----
// Self-checking bench for the VHT capability intersection block.
module vht_capability_intersect_tb;
  import vhtci_pkg::*;
  import vhtci_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned BEATS_PER_PHASE = 250;
  localparam int unsigned PRESSURE_PHASE = 4;
  // Index 7 is not mapped to any register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // Idling modes, one per random phase in rotation.
  localparam int unsigned IDLE_NONE = 0;
  localparam int unsigned IDLE_SENDER = 1;
  localparam int unsigned IDLE_RECEIVER = 2;
  localparam int unsigned IDLE_BOTH = 3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        recv_hold = 1'b0;
  int unsigned cycles = 0;

  capability_scoreboard sb = new();

  vht_capability_intersect dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the edge, before the block's registers
  // move, so a beat counts when valid was high and our stall was low. The next
  // stall value is then chosen: forced high during a hold-off, random otherwise.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one beat after a random number of idle cycles and returns at the
  // edge where it was taken. Valid stays high into the next call when no gap
  // follows, so it is never dropped and raised in one step.
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
  endtask

  // Stops offering and waits for every owed result. Each beat yields exactly
  // one result, so once the last one is out the block holds nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Writes every register. The single-bit ones get random upper bits, which
  // the block has to ignore, and the unmapped index gets a random word.
  task automatic configure(input cfg_t c);
    settle();
    drive_reg(REG_LOCAL_CAPS, c.local_caps);
    drive_reg(REG_LOCAL_RX_MCS_MAP, {16'($urandom_range(65535)), c.local_rx_mcs_map});
    drive_reg(REG_LOCAL_TX_MCS_MAP, {16'($urandom_range(65535)), c.local_tx_mcs_map});
    drive_reg(REG_ALLOW_80P80, ($urandom & ~32'h1) | 32'(c.allow_80p80));
    drive_reg(REG_ALLOW_160, ($urandom & ~32'h1) | 32'(c.allow_160));
    drive_reg(REG_STBC_TX_ON, ($urandom & ~32'h1) | 32'(c.stbc_tx_on));
    drive_reg(REG_STBC_RX_ON, ($urandom & ~32'h1) | 32'(c.stbc_rx_on));
    drive_reg(REG_UNMAPPED, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    send_idle_pct <= (mode == IDLE_SENDER) ? 68 : (mode == IDLE_BOTH) ? 29 : 0;
    recv_stall_pct <= (mode == IDLE_RECEIVER) ? 68 : (mode == IDLE_BOTH) ? 29 : 0;
  endtask

  function automatic in_beat_t peer_beat(logic [31:0] caps, logic [15:0] map, logic sta);
    in_beat_t b;
    b.peer_caps = caps;
    b.peer_tx_mcs_map = map;
    b.station_mode = sta;
    return b;
  endfunction

  // Random word leaning toward ones, toward zeros or flat, so that min, max
  // and parent-bit gating see both equal and unequal operands often.
  function automatic logic [31:0] skewed_word();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v = v | $urandom;
      1: v = v & $urandom;
      default: ;
    endcase
    return v;
  endfunction

  // The first three phases pin the extremes; the rest are random.
  function automatic cfg_t phase_setting(int unsigned ph);
    cfg_t c;
    c.local_caps = skewed_word();
    c.local_rx_mcs_map = skewed_word();
    c.local_tx_mcs_map = skewed_word();
    c.allow_80p80 = 1'($urandom_range(1));
    c.allow_160 = 1'($urandom_range(1));
    c.stbc_tx_on = 1'($urandom_range(1));
    c.stbc_rx_on = 1'($urandom_range(1));
    case (ph)
      0: c = {32'hFFFF_FFFF, 16'h0000, 16'h0000, 4'b1111};
      1: c = {32'h0000_0000, 16'hFFFF, 16'hFFFF, 4'b0000};
      2: c = {32'hFFFF_FFFF, c.local_rx_mcs_map, c.local_tx_mcs_map, 4'b0000};
      default: ;
    endcase
    return c;
  endfunction

  // Station mode dominates since that is where the peer word matters; the
  // access-point beats check that the peer is really ignored.
  function automatic in_beat_t random_beat();
    return peer_beat(skewed_word(), skewed_word(), $urandom_range(99) < 75);
  endfunction

  initial begin
    int unsigned ph;
    int unsigned n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: local word all zero, so only the antenna-pattern bits,
    // which take the maximum, can come through from the peer.
    send_beat(peer_beat(32'hFFFF_FFFF, 16'h0000, 1'b1));
    send_beat(peer_beat(32'h3000_0000, 16'h1B1B, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFFF, 16'h0000, 1'b0));

    // Everything permitted, local word all ones, local TX lanes 0,1,2,3 twice.
    configure({32'hFFFF_FFFF, 16'h5A3C, 16'hE4E4, 4'b1111});
    send_beat(peer_beat(32'h0000_0000, 16'h0000, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFFF, 16'h0000, 1'b0));
    send_beat(peer_beat(32'h0000_0000, 16'h1B1B, 1'b0));
    // Each channel width value from the peer.
    send_beat(peer_beat(32'hFFFF_FFFF, 16'h1B1B, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFFB, 16'h1B1B, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFF7, 16'h1B1B, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFF3, 16'h1B1B, 1'b1));
    // Peer without RX STBC, then peer without TX STBC.
    send_beat(peer_beat(32'hFFFF_F8FF, 16'hE4E4, 1'b1));
    send_beat(peer_beat(32'hFFFF_FF7F, 16'hE4E4, 1'b1));
    // Missing SU beamformer, SU beamformee and HTC-VHT parents.
    send_beat(peer_beat(32'hFFFF_F7FF, 16'h4E4E, 1'b1));
    send_beat(peer_beat(32'hFFFF_EFFF, 16'h4E4E, 1'b1));
    send_beat(peer_beat(32'hFFBF_FFFF, 16'h4E4E, 1'b1));

    // 80+80 barred, 160 allowed, TX STBC barred.
    configure({32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 4'b0101});
    send_beat(peer_beat(32'hFFFF_FFFB, 16'h0000, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFF7, 16'hFFFF, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFFF, 16'h0000, 1'b0));

    // Both wide modes barred, RX STBC barred, local width 80+80. The reserved
    // width value from the peer is not lowered; the local one in access-point
    // mode is lowered all the way.
    configure({32'hFFFF_FFFB, 16'h0000, 16'hFFFF, 4'b0010});
    send_beat(peer_beat(32'hFFFF_FFFB, 16'h0000, 1'b1));
    send_beat(peer_beat(32'hFFFF_FFFF, 16'h0000, 1'b1));
    send_beat(peer_beat(32'h0000_0000, 16'h0000, 1'b0));

    // Random phases, rotating through the idling modes. In one phase the
    // receiver holds off for a long stretch while beats keep coming, so the
    // block fills and pushes back on its input.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      configure(phase_setting(ph));
      set_idling(ph % 4);
      if (ph == PRESSURE_PHASE) begin
        fork
          begin
            recv_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            recv_hold <= 1'b0;
          end
        join_none
      end
      for (n = 0; n < BEATS_PER_PHASE; n++) send_beat(random_beat());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failed()) begin
      $display("end of test: mismatches");
    end else begin
      $display("end of test: clean");
    end
    $finish;
  end

endmodule
